[rtl/core/complex_arithmetic_unit_macros.svh]
// Assertion helpers for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cau_pkg.sv]
`default_nettype none
package cau_pkg;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // per-beat control that travels along the pipeline
  typedef struct packed {
    logic vld;
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
    logic pre_sat;
  } cau_ctl_t;

endpackage
`default_nettype wire

[rtl/core/cau_front.sv]
`default_nettype none
module cau_front #(
  parameter int DW = 16,
  parameter int F  = 8,
  parameter int MW = 2 * DW
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           in_mode,
  input  wire logic signed [DW-1:0] in_a_re,
  input  wire logic signed [DW-1:0] in_a_im,
  input  wire logic signed [DW-1:0] in_b_re,
  input  wire logic signed [DW-1:0] in_b_im,
  output cau_pkg::cau_ctl_t         ctl_o,
  output logic [2*DW-1:0]           side_o,
  output logic [MW-1:0]             den_o,
  output logic [MW-1:0]             rem_re_o,
  output logic [MW-1:0]             rem_im_o,
  output logic [DW-1:0]             low_re_o,
  output logic [DW-1:0]             low_im_o
);

  localparam int SUMW = MW + 1;
  localparam int NSW  = MW + F;
  localparam logic signed [SUMW-1:0] MAXV = {{(SUMW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] MINV = {{(SUMW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINW = {1'b1, {(DW-1){1'b0}}};

  // stage 1: products and part-wise add/sub
  logic                   vld1_r;
  logic [1:0]             mode1_r;
  logic signed [MW-1:0]   p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r, p_brbr_r, p_bibi_r;
  logic signed [MW-1:0]   p_arbr_nxt, p_aibi_nxt, p_arbi_nxt, p_aibr_nxt, p_brbr_nxt, p_bibi_nxt;
  logic signed [DW:0]     as_re_r, as_im_r, as_re_nxt, as_im_nxt;

  assign p_arbr_nxt = in_a_re * in_b_re;
  assign p_aibi_nxt = in_a_im * in_b_im;
  assign p_arbi_nxt = in_a_re * in_b_im;
  assign p_aibr_nxt = in_a_im * in_b_re;
  assign p_brbr_nxt = in_b_re * in_b_re;
  assign p_bibi_nxt = in_b_im * in_b_im;

  always_comb begin
    if (in_mode == cau_pkg::MODE_SUB) begin
      as_re_nxt = (DW+1)'(in_a_re) - (DW+1)'(in_b_re);
      as_im_nxt = (DW+1)'(in_a_im) - (DW+1)'(in_b_im);
    end else begin
      as_re_nxt = (DW+1)'(in_a_re) + (DW+1)'(in_b_re);
      as_im_nxt = (DW+1)'(in_a_im) + (DW+1)'(in_b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r  <= in_mode;
      p_arbr_r <= p_arbr_nxt;
      p_aibi_r <= p_aibi_nxt;
      p_arbi_r <= p_arbi_nxt;
      p_aibr_r <= p_aibr_nxt;
      p_brbr_r <= p_brbr_nxt;
      p_bibi_r <= p_bibi_nxt;
      as_re_r  <= as_re_nxt;
      as_im_r  <= as_im_nxt;
    end
  end

  // stage 2: sums of products, non-divide results clipped here
  logic signed [SUMW-1:0] mre, mim, nre, nim, sel_re, sel_im;
  logic [MW-1:0]          den_nxt, mag_re_nxt, mag_im_nxt;
  logic                   is_div, dz_nxt, sat_re, sat_im;
  logic [DW-1:0]          pre_re_nxt, pre_im_nxt;

  assign mre = (SUMW'(p_arbr_r) - SUMW'(p_aibi_r)) >>> F;
  assign mim = (SUMW'(p_arbi_r) + SUMW'(p_aibr_r)) >>> F;
  assign nre = SUMW'(p_arbr_r) + SUMW'(p_aibi_r);
  assign nim = SUMW'(p_aibr_r) - SUMW'(p_arbi_r);
  assign den_nxt = $unsigned(p_brbr_r) + $unsigned(p_bibi_r);
  assign is_div = (mode1_r == cau_pkg::MODE_DIV);
  assign dz_nxt = is_div && (den_nxt == '0);

  assign mag_re_nxt = nre[SUMW-1] ? MW'(-nre) : MW'(nre);
  assign mag_im_nxt = nim[SUMW-1] ? MW'(-nim) : MW'(nim);

  always_comb begin
    unique case (mode1_r)
      cau_pkg::MODE_MUL: begin
        sel_re = mre;
        sel_im = mim;
      end
      cau_pkg::MODE_DIV: begin
        sel_re = '0;
        sel_im = '0;
      end
      default: begin
        sel_re = SUMW'(as_re_r);
        sel_im = SUMW'(as_im_r);
      end
    endcase
    sat_re = (sel_re > MAXV) || (sel_re < MINV);
    sat_im = (sel_im > MAXV) || (sel_im < MINV);
    pre_re_nxt = (sel_re > MAXV) ? MAXW : (sel_re < MINV) ? MINW : sel_re[DW-1:0];
    pre_im_nxt = (sel_im > MAXV) ? MAXW : (sel_im < MINV) ? MINW : sel_im[DW-1:0];
  end

  cau_pkg::cau_ctl_t ctl2_r, ctl2_nxt;
  logic [DW-1:0]     pre_re_r, pre_im_r;
  logic [MW-1:0]     mag_re_r, mag_im_r, den2_r;

  always_comb begin
    ctl2_nxt         = '0;
    ctl2_nxt.vld     = vld1_r;
    ctl2_nxt.is_div  = is_div;
    ctl2_nxt.dz      = dz_nxt;
    ctl2_nxt.neg_re  = nre[SUMW-1];
    ctl2_nxt.neg_im  = nim[SUMW-1];
    ctl2_nxt.pre_sat = sat_re || sat_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_re_r <= pre_re_nxt;
      pre_im_r <= pre_im_nxt;
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      den2_r   <= den_nxt;
    end
  end

  // stage 3: overflow precheck and initial remainder for the divider chain
  logic [NSW-1:0]    ns_re, ns_im, hi_re, hi_im;
  cau_pkg::cau_ctl_t ctl3_r, ctl3_nxt;
  logic [2*DW-1:0]   side_r;
  logic [MW-1:0]     den3_r, rem_re_r, rem_im_r;
  logic [DW-1:0]     low_re_r, low_im_r;

  assign ns_re = NSW'(mag_re_r) << F;
  assign ns_im = NSW'(mag_im_r) << F;
  assign hi_re = ns_re >> DW;
  assign hi_im = ns_im >> DW;

  always_comb begin
    ctl3_nxt        = ctl2_r;
    ctl3_nxt.big_re = hi_re >= NSW'(den2_r);
    ctl3_nxt.big_im = hi_im >= NSW'(den2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (en) begin
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= {pre_re_r, pre_im_r};
      den3_r   <= den2_r;
      rem_re_r <= hi_re[MW-1:0];
      rem_im_r <= hi_im[MW-1:0];
      low_re_r <= ns_re[DW-1:0];
      low_im_r <= ns_im[DW-1:0];
    end
  end

  assign ctl_o    = ctl3_r;
  assign side_o   = side_r;
  assign den_o    = den3_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign low_re_o = low_re_r;
  assign low_im_o = low_im_r;

endmodule
`default_nettype wire

[rtl/core/cau_div_cell.sv]
`default_nettype none
module cau_div_cell #(
  parameter int DW = 16,
  parameter int MW = 2 * DW,
  parameter int SW = 2 * DW
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire cau_pkg::cau_ctl_t ctl_i,
  input  wire logic [SW-1:0]     side_i,
  input  wire logic [MW-1:0]     den_i,
  input  wire logic [MW-1:0]     rem_re_i,
  input  wire logic [MW-1:0]     rem_im_i,
  input  wire logic [DW-1:0]     low_re_i,
  input  wire logic [DW-1:0]     low_im_i,
  input  wire logic [DW-1:0]     q_re_i,
  input  wire logic [DW-1:0]     q_im_i,
  output cau_pkg::cau_ctl_t      ctl_o,
  output logic [SW-1:0]          side_o,
  output logic [MW-1:0]          den_o,
  output logic [MW-1:0]          rem_re_o,
  output logic [MW-1:0]          rem_im_o,
  output logic [DW-1:0]          low_re_o,
  output logic [DW-1:0]          low_im_o,
  output logic [DW-1:0]          q_re_o,
  output logic [DW-1:0]          q_im_o
);

  // one restoring step per lane: bring in next numerator bit, try subtract
  logic [MW:0]   tr_re, tr_im;
  logic          ge_re, ge_im;
  logic [MW-1:0] rem_re_nxt, rem_im_nxt;

  assign tr_re = {rem_re_i, low_re_i[DW-1]};
  assign tr_im = {rem_im_i, low_im_i[DW-1]};
  assign ge_re = tr_re >= {1'b0, den_i};
  assign ge_im = tr_im >= {1'b0, den_i};
  assign rem_re_nxt = ge_re ? MW'(tr_re - {1'b0, den_i}) : MW'(tr_re);
  assign rem_im_nxt = ge_im ? MW'(tr_im - {1'b0, den_i}) : MW'(tr_im);

  cau_pkg::cau_ctl_t ctl_r;
  logic [SW-1:0]     side_r;
  logic [MW-1:0]     den_r, rem_re_r, rem_im_r;
  logic [DW-1:0]     low_re_r, low_im_r, q_re_r, q_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= side_i;
      den_r    <= den_i;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      low_re_r <= low_re_i << 1;
      low_im_r <= low_im_i << 1;
      q_re_r   <= {q_re_i[DW-2:0], ge_re};
      q_im_r   <= {q_im_i[DW-2:0], ge_im};
    end
  end

  assign ctl_o    = ctl_r;
  assign side_o   = side_r;
  assign den_o    = den_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign low_re_o = low_re_r;
  assign low_im_o = low_im_r;
  assign q_re_o   = q_re_r;
  assign q_im_o   = q_im_r;

endmodule
`default_nettype wire

[rtl/core/complex_arithmetic_unit.sv]
// channel | handshake          | payload
// in      | in_valid/in_ready  | in_mode, in_a_re, in_a_im, in_b_re, in_b_im
// out     | out_valid/out_ready| out_res_re, out_res_im, out_saturated, out_div_by_zero
//
// One beat per cycle sustained while the output is not stalled; every mode takes the same path.
// The divider chain has one cell per quotient bit, DATA_WIDTH cells.
// Three front stages (products, sums, overflow precheck) precede it and the output register follows it.
// The whole pipeline advances together: it stalls only while a result waits in the
// output register and out_ready is low. Reset (rst_n low, synchronous) clears valids.
`default_nettype none
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_mode,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_res_re,
  output logic signed [DATA_WIDTH-1:0]      out_res_im,
  output logic                              out_saturated,
  output logic                              out_div_by_zero
);

  localparam int DW = DATA_WIDTH;
  localparam int MW = 2 * DW;
  localparam int SW = 2 * DW;
  localparam logic [DW-1:0] MAXW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINW = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW:0]   LIM  = {2'b01, {(DW-1){1'b0}}};

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  cau_pkg::cau_ctl_t ctl   [DW+1];
  logic [SW-1:0]     side  [DW+1];
  logic [MW-1:0]     den   [DW+1];
  logic [MW-1:0]     rem_re[DW+1];
  logic [MW-1:0]     rem_im[DW+1];
  logic [DW-1:0]     low_re[DW+1];
  logic [DW-1:0]     low_im[DW+1];
  logic [DW-1:0]     q_re  [DW+1];
  logic [DW-1:0]     q_im  [DW+1];

  cau_front #(.DW(DW), .F(FRAC_BITS), .MW(MW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_a_re  (in_a_re),
    .in_a_im  (in_a_im),
    .in_b_re  (in_b_re),
    .in_b_im  (in_b_im),
    .ctl_o    (ctl[0]),
    .side_o   (side[0]),
    .den_o    (den[0]),
    .rem_re_o (rem_re[0]),
    .rem_im_o (rem_im[0]),
    .low_re_o (low_re[0]),
    .low_im_o (low_im[0])
  );

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    cau_div_cell #(.DW(DW), .MW(MW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (ctl[k]),
      .side_i   (side[k]),
      .den_i    (den[k]),
      .rem_re_i (rem_re[k]),
      .rem_im_i (rem_im[k]),
      .low_re_i (low_re[k]),
      .low_im_i (low_im[k]),
      .q_re_i   (q_re[k]),
      .q_im_i   (q_im[k]),
      .ctl_o    (ctl[k+1]),
      .side_o   (side[k+1]),
      .den_o    (den[k+1]),
      .rem_re_o (rem_re[k+1]),
      .rem_im_o (rem_im[k+1]),
      .low_re_o (low_re[k+1]),
      .low_im_o (low_im[k+1]),
      .q_re_o   (q_re[k+1]),
      .q_im_o   (q_im[k+1])
    );
  end

  // quotient sign and clipping
  cau_pkg::cau_ctl_t lc;
  logic              neg_re, neg_im, dsat_re, dsat_im;
  logic [DW-1:0]     dres_re, dres_im;

  assign lc = ctl[DW];

  always_comb begin
    neg_re = lc.neg_re && (lc.big_re || (q_re[DW] != '0));
    neg_im = lc.neg_im && (lc.big_im || (q_im[DW] != '0));
    if (neg_re) begin
      dsat_re = lc.big_re || ({1'b0, q_re[DW]} > LIM);
      dres_re = dsat_re ? MINW : DW'(-q_re[DW]);
    end else begin
      dsat_re = lc.big_re || q_re[DW][DW-1];
      dres_re = dsat_re ? MAXW : q_re[DW];
    end
    if (neg_im) begin
      dsat_im = lc.big_im || ({1'b0, q_im[DW]} > LIM);
      dres_im = dsat_im ? MINW : DW'(-q_im[DW]);
    end else begin
      dsat_im = lc.big_im || q_im[DW][DW-1];
      dres_im = dsat_im ? MAXW : q_im[DW];
    end
  end

  logic          use_q;
  logic [DW-1:0] res_re_nxt, res_im_nxt, res_re_r, res_im_r;
  logic          sat_nxt, sat_r, dz_r;

  assign use_q      = lc.is_div && !lc.dz;
  assign res_re_nxt = use_q ? dres_re : side[DW][SW-1:DW];
  assign res_im_nxt = use_q ? dres_im : side[DW][DW-1:0];
  assign sat_nxt    = use_q ? (dsat_re || dsat_im) : lc.pre_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lc.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      sat_r    <= sat_nxt;
      dz_r     <= lc.dz;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_re      = res_re_r;
  assign out_res_im      = res_im_r;
  assign out_saturated   = sat_r;
  assign out_div_by_zero = dz_r;

  `CAU_ASSERT_NOW(a_dz_zero, clk, rst_n, out_valid && out_div_by_zero,
    (out_res_re == '0) && (out_res_im == '0) && !out_saturated, "div by zero result not zero")
  `CAU_ASSERT_NOW(a_sat_bound, clk, rst_n, out_valid && out_saturated,
    (res_re_r == MAXW) || (res_re_r == MINW) || (res_im_r == MAXW) || (res_im_r == MINW),
    "saturated flag without a bound value")
  `CAU_ASSERT_NOW(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready,
    "input accepted while output stalled")
  `CAU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && (res_re_r == $past(res_re_r)), "stalled result changed")

endmodule
`default_nettype wire

[dv/tb_complex_arithmetic_unit.sv]
`timescale 1ns / 100ps
module tb_complex_arithmetic_unit;

  localparam int W = 16;
  localparam int FB = 8;
  localparam int N_RANDOM = 1930;
  localparam int DRAIN_CYCLES = 2 * (W + 4) + 10;

  typedef struct {
    logic [1:0]      mode;
    logic signed [W-1:0] a_re, a_im, b_re, b_im;
  } cplx_op_t;

  typedef struct {
    logic signed [W-1:0] re, im;
    logic sat, dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = cau_pkg::MODE_ADD;
  logic signed [W-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [W-1:0] out_res_re, out_res_im;
  logic out_saturated, out_div_by_zero;

  cplx_op_t  op_queue[$];
  cplx_res_t golden_q[$];
  cplx_op_t  cur_op;
  int        send_gap = 0;
  int        stall_left = 0;
  int        errors = 0;
  int        n_checked = 0;
  int        mode_count[4] = '{0, 0, 0, 0};
  int        n_sat = 0, n_dz = 0;

  complex_arithmetic_unit #(.DATA_WIDTH(W), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_saturated(out_saturated), .out_div_by_zero(out_div_by_zero)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // returns {clipped, value}
  function automatic logic [W:0] clip_word(longint v);
    if (v > 32767) return {1'b1, 16'sh7fff};
    if (v < -32768) return {1'b1, 16'sh8000};
    return {1'b0, v[W-1:0]};
  endfunction

  // (n << FB) / den with the sign of n, truncated toward zero
  function automatic longint scaled_quot(longint n, longint den);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag << FB) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t cplx_compute(cplx_op_t op);
    longint ar, ai, br, bi, vr, vi, den;
    logic [W:0] cr, ci;
    cplx_res_t r;
    ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
    r.dz = 1'b0;
    case (op.mode)
      cau_pkg::MODE_ADD: begin vr = ar + br; vi = ai + bi; end
      cau_pkg::MODE_SUB: begin vr = ar - br; vi = ai - bi; end
      cau_pkg::MODE_MUL: begin
        vr = (ar * br - ai * bi) >>> FB;
        vi = (ar * bi + ai * br) >>> FB;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1; vr = 0; vi = 0;
        end else begin
          vr = scaled_quot(ar * br + ai * bi, den);
          vi = scaled_quot(ai * br - ar * bi, den);
        end
      end
    endcase
    cr = clip_word(vr);
    ci = clip_word(vi);
    r.re = cr[W-1:0];
    r.im = ci[W-1:0];
    r.sat = cr[W] | ci[W];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0, 1:    return W'($urandom);
      2, 3:    return W'($urandom_range(0, 2048) - 1024);
      4:       return W'($urandom_range(0, 32) - 16);
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'sh0100;
        endcase
      end
    endcase
  endfunction

  task automatic add_op(logic [1:0] m, logic signed [W-1:0] ar, ai, br, bi);
    cplx_op_t op;
    op.mode = m; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
    op_queue.push_back(op);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        golden_q.push_back(cplx_compute(cur_op));
        mode_count[cur_op.mode]++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          cur_op = op_queue.pop_front();
          in_mode <= cur_op.mode;
          in_a_re <= cur_op.a_re;
          in_a_im <= cur_op.a_im;
          in_b_re <= cur_op.b_re;
          in_b_im <= cur_op.b_im;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (golden_q.size() == 0) begin
        errors++;
        $display("unexpected result beat: re %0d im %0d", out_res_re, out_res_im);
      end else begin
        want = golden_q.pop_front();
        if (out_res_re !== want.re) report_mismatch("res_re", out_res_re, want.re);
        if (out_res_im !== want.im) report_mismatch("res_im", out_res_im, want.im);
        if (out_saturated !== want.sat) report_mismatch("saturated", out_saturated, want.sat);
        if (out_div_by_zero !== want.dz)
          report_mismatch("div_by_zero", out_div_by_zero, want.dz);
        n_sat += want.sat;
        n_dz += want.dz;
        n_checked++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  initial begin
    logic [1:0] m;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // extremes and one moderate case per mode
    for (int k = 0; k < 4; k++) begin
      m = 2'(k);
      add_op(m, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      add_op(m, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      add_op(m, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      add_op(m, 16'sh0180, -16'sh0240, 16'sh0100, 16'sh0080);
    end
    // zero divisor, zero numerator, tiny divisor, floor on negative products, clipped mul and sub, zero add
    add_op(cau_pkg::MODE_DIV, 16'sh1234, -16'sh0042, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::MODE_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    add_op(cau_pkg::MODE_DIV, 16'sh0000, 16'sh0000, 16'sh0003, -16'sh0005);
    add_op(cau_pkg::MODE_DIV, 16'sh0100, 16'sh0000, 16'sh0001, 16'sh0000);
    add_op(cau_pkg::MODE_DIV, -16'sh0001, 16'sh0001, 16'sh0300, 16'sh0000);
    add_op(cau_pkg::MODE_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000);
    add_op(cau_pkg::MODE_MUL, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000);
    add_op(cau_pkg::MODE_SUB, 16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000);
    add_op(cau_pkg::MODE_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    for (int k = 0; k < N_RANDOM; k++) begin
      m = 2'($urandom_range(0, 3));
      if (m == cau_pkg::MODE_DIV && $urandom_range(0, 15) == 0)
        add_op(m, rand_part(), rand_part(), 16'sh0000, 16'sh0000);
      else
        add_op(m, rand_part(), rand_part(), rand_part(), rand_part());
    end

    while (op_queue.size() > 0 || in_valid || golden_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: add %0d sub %0d mul %0d div %0d", n_checked,
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("clipped results %0d, zero divisors %0d, mismatches %0d", n_sat, n_dz, errors);
    if (errors == 0 && golden_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout: %0d results still outstanding", golden_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
